// File: sv/encoder_speed_pi_controller_top_defines.svh
// Assertion macros shared by the encoder speed PI controller RTL.
`ifndef ENCODER_SPEED_PI_CONTROLLER_TOP_DEFINES_SVH
`define ENCODER_SPEED_PI_CONTROLLER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ESPC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ESPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/espc_pkg.sv
// Package with types, constants and helper functions of the encoder speed PI controller.
package espc_pkg;

   localparam int ELAPSED_W       = 24;
   localparam int POS_W           = 32;
   localparam int RPM_W           = 24;
   localparam int DRIVE_W         = 16;
   localparam int INTEG_W         = 48;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 24;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int COEF_POLE  = 55968;
   localparam int COEF_ZERO  = 4771;
   localparam int RPM_SCALE  = 60000000;
   localparam int INT_ROUND  = 500000;
   localparam int RAW_QBITS  = 24;
   localparam int INT_QBITS  = 38;

   // One million is 2^6 times 15625; INT_RECIP is the ceiling of 2^64 / 15625.
   localparam int          INT_DIV_SHIFT = 6;
   localparam logic [50:0] INT_RECIP     = 51'd1180591620717412;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = 3'd0,
      CSR_PROP   = 3'd1,
      CSR_INTEG  = 3'd2,
      CSR_CPR    = 3'd3,
      CSR_LIMIT  = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic signed [23:0] target_rpm;
      logic [15:0]        prop_gain;
      logic [15:0]        integral_gain;
      logic [15:0]        counts_per_rev;
      logic [14:0]        drive_limit;
   } cfg_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] elapsed_us;
      logic [POS_W-1:0]     position;
   } tick_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL, ST_PREP, ST_DIV_RAW, ST_RAW_FIN, ST_FILT_A, ST_FILT_B, ST_FILT_C,
      ST_ERR, ST_INT_MUL, ST_INT_PREP, ST_RCP_LL, ST_RCP_LH, ST_RCP_HL, ST_RCP_HH,
      ST_INT_ADD, ST_KI_LO, ST_KI_HI, ST_KP, ST_SUM, ST_DRIVE, ST_OUT
   } back_state_type;

   function automatic logic signed [63:0] round_shr(input logic signed [63:0] x,
                                                    input int unsigned s);
      logic signed [63:0] half;
      logic signed [63:0] bias;
      half = 64'sd1 <<< (s - 1);
      bias = x[63] ? (half - 64'sd1) : half;
      return (x + bias) >>> s;
   endfunction

   function automatic logic signed [RPM_W-1:0] sat_rpm(input logic signed [63:0] x);
      if (x > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (x < -64'sd8388608) begin
         return 24'sh800000;
      end
      return x[RPM_W-1:0];
   endfunction

endpackage

// File: sv/espc_if.sv
// Valid/ready channel interfaces for the request and response beats.
interface espc_req_if;
   import espc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic                 direction;
   logic [ELAPSED_W-1:0] elapsed_us;
   modport source(output valid, opcode, direction, elapsed_us, input ready);
   modport sink(input valid, opcode, direction, elapsed_us, output ready);
endinterface

interface espc_rsp_if;
   import espc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic signed [RPM_W-1:0]   filtered_rpm;
   logic signed [RPM_W-1:0]   raw_rpm;
   logic signed [POS_W-1:0]   position;
   modport source(output valid, drive, filtered_rpm, raw_rpm, position, input ready);
   modport sink(input valid, drive, filtered_rpm, raw_rpm, position, output ready);
endinterface

// File: sv/espc_queue.sv
// Short FIFO of tick beats between the front and the back.
module espc_queue #(
   parameter int DEPTH = espc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  espc_pkg::tick_type       push_data,
   input  logic                     pop,
   output espc_pkg::tick_type       pop_data,
   output espc_pkg::fifo_stat_type  stat
);
   import espc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tick_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// File: sv/espc_front.sv
// Front end: takes request beats, counts encoder edges and queues control ticks.
module espc_front (
   input  logic                     clock,
   input  logic                     reset,
   espc_req_if.sink                 req,
   input  espc_pkg::fifo_stat_type  stat,
   output logic                     push,
   output espc_pkg::tick_type       push_data
);
   import espc_pkg::*;

   logic [POS_W-1:0] position_ff;
   logic             accept;

   assign req.ready = !stat.full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && (req.opcode == OP_TICK);

   assign push_data.elapsed_us = req.elapsed_us;
   assign push_data.position   = position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else if (accept && (req.opcode == OP_EDGE)) begin
         position_ff <= req.direction ? position_ff + 1'b1 : position_ff - 1'b1;
      end
   end

endmodule

// File: sv/espc_back.sv
// Back end: speed measurement, low-pass filter and PI loop, with a serial divider.
module espc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  espc_pkg::cfg_type        cfg,
   input  espc_pkg::fifo_stat_type  stat,
   input  espc_pkg::tick_type       tick,
   output logic                     pop,
   espc_rsp_if.source               rsp
);
   import espc_pkg::*;

   back_state_type state_ff, state_in;

   logic [ELAPSED_W-1:0]    elapsed_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [POS_W-1:0]        last_pos_ff;
   logic                    neg_ff;
   logic [57:0]             prod_ff;
   logic [39:0]             den_ff;
   logic [65:0]             num_ff;
   logic [65:0]             dsr_ff;
   logic [INT_QBITS-1:0]    quo_ff;
   logic [5:0]              cnt_ff;
   logic [100:0]            rcp_ff;
   logic signed [RPM_W-1:0] raw_ff;
   logic signed [RPM_W-1:0] prev_raw_ff;
   logic signed [RPM_W-1:0] filt_ff;
   logic signed [41:0]      acc_ff;
   logic signed [24:0]      err_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic [39:0]             kilo_ff;
   logic signed [40:0]      kihi_ff;
   logic signed [40:0]      pterm_ff;
   logic signed [63:0]      isum_ff;
   logic signed [DRIVE_W-1:0] drive_ff;

   logic                    rsp_valid_ff;
   logic signed [DRIVE_W-1:0] rsp_drive_ff;
   logic signed [RPM_W-1:0] rsp_filt_ff;
   logic signed [RPM_W-1:0] rsp_raw_ff;
   logic [POS_W-1:0]        rsp_pos_ff;
   logic                    load_rsp;

   logic [POS_W-1:0]        d_w;
   logic [POS_W-1:0]        mag_w;
   logic [15:0]             cpr_w;
   logic [65:0]             num_raw_w;
   logic                    sat_w;
   logic                    ge_w;
   logic [INT_QBITS-1:0]    qcap_w;
   logic signed [24:0]      rsum_w;
   logic [24:0]             emag_w;
   logic [25:0]             ry_w;
   logic [25:0]             rm_w;
   logic [51:0]             rpp_w;
   logic [36:0]             rquo_w;
   logic signed [49:0]      isum50_w;
   logic signed [63:0]      kprod_w;
   logic signed [63:0]      tot_w;
   logic signed [63:0]      lim_w;

   assign d_w       = pos_ff - last_pos_ff;
   assign mag_w     = d_w[POS_W-1] ? (32'd0 - d_w) : d_w;
   assign cpr_w     = (cfg.counts_per_rev == '0) ? 16'd1 : cfg.counts_per_rev;
   assign num_raw_w = {prod_ff, 8'b0} + 66'(den_ff >> 1);
   assign sat_w     = num_raw_w >= (66'(den_ff) << RAW_QBITS);
   assign ge_w      = num_ff >= dsr_ff;
   assign rsum_w    = 25'(raw_ff) + 25'(prev_raw_ff);
   assign emag_w    = err_ff[24] ? 25'(-err_ff) : 25'(err_ff);
   assign rpp_w     = 52'(ry_w) * 52'(rm_w);
   assign rquo_w    = rcp_ff[100:64];
   assign isum50_w  = 50'(integ_ff)
                      + (neg_ff ? -$signed({13'b0, rquo_w}) : $signed({13'b0, rquo_w}));
   assign kprod_w   = (64'(kihi_ff) <<< 24) + $signed({24'b0, kilo_ff});
   assign tot_w     = round_shr(64'(pterm_ff) + isum_ff, 16);
   assign lim_w     = $signed({49'b0, cfg.drive_limit});

   always_comb begin
      if (neg_ff) begin
         qcap_w = (quo_ff > INT_QBITS'(24'h800000)) ? INT_QBITS'(24'h800000) : quo_ff;
      end else begin
         qcap_w = (quo_ff > INT_QBITS'(24'h7FFFFF)) ? INT_QBITS'(24'h7FFFFF) : quo_ff;
      end
   end

   always_comb begin
      ry_w = '0;
      rm_w = '0;
      unique case (state_ff)
         ST_RCP_LL: begin
            ry_w = {1'b0, num_ff[24:0]};
            rm_w = INT_RECIP[25:0];
         end
         ST_RCP_LH: begin
            ry_w = {1'b0, num_ff[24:0]};
            rm_w = {1'b0, INT_RECIP[50:26]};
         end
         ST_RCP_HL: begin
            ry_w = {1'b0, num_ff[49:25]};
            rm_w = INT_RECIP[25:0];
         end
         ST_RCP_HH: begin
            ry_w = {1'b0, num_ff[49:25]};
            rm_w = {1'b0, INT_RECIP[50:26]};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!stat.empty) begin
               pop      = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL:      state_in = ST_PREP;
         ST_PREP: begin
            if (elapsed_ff == '0 || sat_w) begin
               state_in = ST_FILT_A;
            end else begin
               state_in = ST_DIV_RAW;
            end
         end
         ST_DIV_RAW:  state_in = (cnt_ff == '0) ? ST_RAW_FIN : ST_DIV_RAW;
         ST_RAW_FIN:  state_in = ST_FILT_A;
         ST_FILT_A:   state_in = ST_FILT_B;
         ST_FILT_B:   state_in = ST_FILT_C;
         ST_FILT_C:   state_in = ST_ERR;
         ST_ERR:      state_in = ST_INT_MUL;
         ST_INT_MUL:  state_in = ST_INT_PREP;
         ST_INT_PREP: state_in = ST_RCP_LL;
         ST_RCP_LL:   state_in = ST_RCP_LH;
         ST_RCP_LH:   state_in = ST_RCP_HL;
         ST_RCP_HL:   state_in = ST_RCP_HH;
         ST_RCP_HH:   state_in = ST_INT_ADD;
         ST_INT_ADD:  state_in = ST_KI_LO;
         ST_KI_LO:    state_in = ST_KI_HI;
         ST_KI_HI:    state_in = ST_KP;
         ST_KP:       state_in = ST_SUM;
         ST_SUM:      state_in = ST_DRIVE;
         ST_DRIVE:    state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= '0;
         prev_raw_ff <= '0;
         filt_ff     <= '0;
         integ_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               elapsed_ff <= tick.elapsed_us;
               pos_ff     <= tick.position;
            end
            ST_MUL: begin
               neg_ff      <= d_w[POS_W-1];
               prod_ff     <= 58'(mag_w) * 58'(RPM_SCALE);
               den_ff      <= 40'(cpr_w) * 40'(elapsed_ff);
               last_pos_ff <= pos_ff;
            end
            ST_PREP: begin
               num_ff <= num_raw_w;
               dsr_ff <= 66'(den_ff) << (RAW_QBITS - 1);
               cnt_ff <= 6'(RAW_QBITS - 1);
               quo_ff <= '0;
               if (elapsed_ff == '0) begin
                  raw_ff <= prev_raw_ff;
               end else if (sat_w) begin
                  raw_ff <= neg_ff ? 24'sh800000 : 24'sh7FFFFF;
               end
            end
            ST_DIV_RAW: begin
               if (ge_w) begin
                  num_ff <= num_ff - dsr_ff;
               end
               quo_ff <= {quo_ff[INT_QBITS-2:0], ge_w};
               dsr_ff <= dsr_ff >> 1;
               cnt_ff <= cnt_ff - 1'b1;
            end
            ST_RAW_FIN: begin
               raw_ff <= neg_ff ? RPM_W'(-$signed({1'b0, qcap_w})) : RPM_W'(qcap_w);
            end
            ST_FILT_A: begin
               acc_ff <= 42'(filt_ff) * 42'(COEF_POLE);
            end
            ST_FILT_B: begin
               acc_ff <= acc_ff + 42'(rsum_w) * 42'(COEF_ZERO);
            end
            ST_FILT_C: begin
               filt_ff     <= sat_rpm(round_shr(64'(acc_ff), 16));
               prev_raw_ff <= raw_ff;
            end
            ST_ERR: begin
               err_ff <= 25'(cfg.target_rpm) - 25'(filt_ff);
            end
            ST_INT_MUL: begin
               neg_ff  <= err_ff[24];
               prod_ff <= 58'(emag_w) * 58'(elapsed_ff);
            end
            ST_INT_PREP: begin
               num_ff <= ({prod_ff, 8'b0} + 66'(INT_ROUND)) >> INT_DIV_SHIFT;
               rcp_ff <= '0;
            end
            ST_RCP_LL: begin
               rcp_ff <= rcp_ff + 101'(rpp_w);
            end
            ST_RCP_LH: begin
               rcp_ff <= rcp_ff + (101'(rpp_w) << 26);
            end
            ST_RCP_HL: begin
               rcp_ff <= rcp_ff + (101'(rpp_w) << 25);
            end
            ST_RCP_HH: begin
               rcp_ff <= rcp_ff + (101'(rpp_w) << 51);
            end
            ST_INT_ADD: begin
               if (isum50_w > 50'sh7FFFFFFFFFFF) begin
                  integ_ff <= 48'sh7FFFFFFFFFFF;
               end else if (isum50_w < -50'sh800000000000) begin
                  integ_ff <= 48'sh800000000000;
               end else begin
                  integ_ff <= isum50_w[INTEG_W-1:0];
               end
            end
            ST_KI_LO: begin
               kilo_ff <= 40'(cfg.integral_gain) * 40'(integ_ff[23:0]);
            end
            ST_KI_HI: begin
               kihi_ff <= 41'($signed(integ_ff[47:24])) * $signed({25'b0, cfg.integral_gain});
            end
            ST_KP: begin
               pterm_ff <= 41'(err_ff) * $signed({25'b0, cfg.prop_gain});
            end
            ST_SUM: begin
               isum_ff <= round_shr(kprod_w, 8);
            end
            ST_DRIVE: begin
               if (tot_w > lim_w) begin
                  drive_ff <= DRIVE_W'(lim_w);
               end else if (tot_w < -lim_w) begin
                  drive_ff <= DRIVE_W'(-lim_w);
               end else begin
                  drive_ff <= tot_w[DRIVE_W-1:0];
               end
            end
            ST_OUT: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_drive_ff <= drive_ff;
         rsp_filt_ff  <= filt_ff;
         rsp_raw_ff   <= raw_ff;
         rsp_pos_ff   <= pos_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.drive        = rsp_drive_ff;
   assign rsp.filtered_rpm = rsp_filt_ff;
   assign rsp.raw_rpm      = rsp_raw_ff;
   assign rsp.position     = $signed(rsp_pos_ff);

endmodule

// File: sv/encoder_speed_pi_controller_top.sv
// Encoder edges update the position in the cycle they are accepted and never produce a
// beat; each control tick produces one response beat. Ticks wait in a four-entry queue and
// are processed one at a time: from leaving the queue to loading its response register, a
// tick goes through 24 restoring divider steps for the raw speed, four partial products
// of a reciprocal multiply for the integral increment, and the multiplies, filtering and
// saturation; a zero elapsed time or a saturated speed skips the division. The response
// beat is offered the cycle after it is loaded, and the back end waits while the previous
// beat is still unaccepted. While the queue is full no request beat is accepted, edges
// included.
module encoder_speed_pi_controller_top #(
   parameter int QUEUE_DEPTH = espc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   espc_req_if.sink                           req_bus,
   espc_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [espc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [espc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import espc_pkg::*;

   cfg_type       cfg_ff;
   fifo_stat_type q_stat;
   tick_type      q_in;
   tick_type      q_out;
   logic          q_push;
   logic          q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_rpm     <= '0;
         cfg_ff.prop_gain      <= 16'd2560;
         cfg_ff.integral_gain  <= 16'd26;
         cfg_ff.counts_per_rev <= 16'd1000;
         cfg_ff.drive_limit    <= 15'd32767;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TARGET: cfg_ff.target_rpm     <= $signed(csr_wdata);
            CSR_PROP:   cfg_ff.prop_gain      <= csr_wdata[15:0];
            CSR_INTEG:  cfg_ff.integral_gain  <= csr_wdata[15:0];
            CSR_CPR:    cfg_ff.counts_per_rev <= csr_wdata[15:0];
            CSR_LIMIT:  cfg_ff.drive_limit    <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   espc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .stat      (q_stat),
      .push      (q_push),
      .push_data (q_in)
   );

   espc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .stat      (q_stat)
   );

   espc_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .stat  (q_stat),
      .tick  (q_out),
      .pop   (q_pop),
      .rsp   (rsp_bus)
   );

`include "encoder_speed_pi_controller_top_defines.svh"

   `ESPC_ASSERT_SAME(a_push_not_full, q_push, !q_stat.full, "tick queued into a full queue")
   `ESPC_ASSERT_SAME(a_pop_not_empty, q_pop, !q_stat.empty, "tick taken from an empty queue")
   `ESPC_ASSERT_NEXT(a_pop_starts_work, q_pop, !q_pop, "back end took two ticks in a row")

endmodule

// File: tb/tb_encoder_speed_pi_controller_top.sv
// Self-checking testbench of the encoder speed PI controller with a built-in speed predictor.
module tb_encoder_speed_pi_controller_top;
   import espc_pkg::*;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [RPM_W-1:0]   filtered_rpm;
      logic signed [RPM_W-1:0]   raw_rpm;
      logic signed [POS_W-1:0]   position;
   } speed_report_type;

   typedef struct {
      logic                 opcode;
      logic                 direction;
      logic [ELAPSED_W-1:0] elapsed_us;
      bit                   typed;
      speed_report_type     known;
   } stim_row_type;

   localparam longint RPM_HI   = 64'sd8388607;
   localparam longint RPM_LO   = -64'sd8388608;
   localparam longint INTEG_HI = 64'sd140737488355327;
   localparam longint INTEG_LO = -64'sd140737488355328;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   espc_req_if req();
   espc_rsp_if rsp();

   encoder_speed_pi_controller_top uut (
      .clock(clock), .reset(reset), .req_bus(req), .rsp_bus(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   cfg_type           cfg;
   logic [31:0]       count_now;
   logic [31:0]       count_at_tick;
   longint            prev_raw;
   longint            filt_speed;
   longint            err_integral;
   speed_report_type  pending_reports[$];
   int                mismatches = 0;
   int                beats_seen = 0;
   bit                quiet = 1'b0;
   bit                hold_off = 1'b0;

   initial begin
      #(8 * 800000);
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic longint round_away(input longint x, input int s);
      longint unsigned m;
      m = (x < 0) ? -x : x;
      m = (m + (64'd1 << (s - 1))) >> s;
      return (x < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic longint unsigned speed_magnitude(input logic [31:0] mag,
      input logic [23:0] el, input logic [15:0] cpr, input longint unsigned cap);
      longint unsigned p, den, qp, rp, q;
      p   = longint'(mag) * 64'd60000000;
      den = longint'(cpr) * longint'(el);
      qp  = p / den;
      rp  = p % den;
      if (qp >= 32768) return cap;
      q = qp * 256 + (rp * 256 + den / 2) / den;
      return (q > cap) ? cap : q;
   endfunction

   function automatic speed_report_type predict_tick(input logic [23:0] el);
      speed_report_type r;
      logic [31:0] d;
      logic [15:0] cpr;
      longint raw, acc, e, total, drv, lim;
      longint unsigned m;
      d = count_now - count_at_tick;
      count_at_tick = count_now;
      if (el == 0) begin
         raw = prev_raw;
      end else begin
         cpr = (cfg.counts_per_rev == 0) ? 16'd1 : cfg.counts_per_rev;
         if (d[31]) raw = -longint'(speed_magnitude(-d, el, cpr, 8388608));
         else raw = longint'(speed_magnitude(d, el, cpr, 8388607));
      end
      acc = 64'sd55968 * filt_speed + 64'sd4771 * (raw + prev_raw);
      filt_speed = clip(round_away(acc, 16), RPM_LO, RPM_HI);
      prev_raw = raw;
      e = longint'(cfg.target_rpm) - filt_speed;
      m = (e < 0) ? -e : e;
      m = (m * el * 256 + 500000) / 1000000;
      err_integral = clip(err_integral + ((e < 0) ? -longint'(m) : longint'(m)),
                          INTEG_LO, INTEG_HI);
      total = longint'(cfg.prop_gain) * e
            + round_away(longint'(cfg.integral_gain) * err_integral, 8);
      lim = longint'(cfg.drive_limit);
      drv = clip(round_away(total, 16), -lim, lim);
      r.drive = drv[15:0];
      r.filtered_rpm = filt_speed[23:0];
      r.raw_rpm = raw[23:0];
      r.position = count_now;
      return r;
   endfunction

   task automatic write_reg(input csr_idx_type idx, input logic [23:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TARGET: cfg.target_rpm = data;
         CSR_PROP:   cfg.prop_gain = data[15:0];
         CSR_INTEG:  cfg.integral_gain = data[15:0];
         CSR_CPR:    cfg.counts_per_rev = data[15:0];
         CSR_LIMIT:  cfg.drive_limit = data[14:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic send_beat(input logic op, input logic dir, input logic [23:0] el,
                            input bit typed, input speed_report_type known);
      bit taken;
      speed_report_type r;
      req.valid <= 1'b1;
      req.opcode <= op;
      req.direction <= dir;
      req.elapsed_us <= el;
      do begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end while (!taken);
      if (op == OP_EDGE) begin
         count_now = count_now + (dir ? 32'd1 : 32'hFFFF_FFFF);
      end else begin
         r = predict_tick(el);
         pending_reports.push_back(typed ? known : r);
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      int held;
      wait (!reset);
      wait (beats_seen == 30);
      hold_off = 1'b1;
      force_hold: for (held = 0; held < 300; held++) begin
         @(posedge clock);
      end
      hold_off = 1'b0;
   end

   always @(negedge clock) begin
      speed_report_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         beats_seen++;
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp.drive !== want.drive)
               report_mismatch("drive", rsp.drive, want.drive);
            if (rsp.filtered_rpm !== want.filtered_rpm)
               report_mismatch("filtered_rpm", rsp.filtered_rpm, want.filtered_rpm);
            if (rsp.raw_rpm !== want.raw_rpm)
               report_mismatch("raw_rpm", rsp.raw_rpm, want.raw_rpm);
            if (rsp.position !== want.position)
               report_mismatch("position", rsp.position, want.position);
         end
      end
   end

   stim_row_type directed_rows[] = '{
      '{OP_TICK, 1'b0, 24'd1000, 1'b1, '0},
      '{OP_TICK, 1'b1, 24'd0, 1'b1, '0},
      '{OP_EDGE, 1'b1, 24'd0, 1'b0, '0},
      '{OP_EDGE, 1'b1, 24'hFFFFFF, 1'b0, '0},
      '{OP_EDGE, 1'b1, 24'd0, 1'b0, '0},
      '{OP_EDGE, 1'b0, 24'd0, 1'b0, '0},
      '{OP_TICK, 1'b0, 24'd1, 1'b0, '0},
      '{OP_TICK, 1'b0, 24'd0, 1'b0, '0},
      '{OP_EDGE, 1'b0, 24'd0, 1'b0, '0},
      '{OP_EDGE, 1'b0, 24'd0, 1'b0, '0},
      '{OP_EDGE, 1'b0, 24'd0, 1'b0, '0},
      '{OP_TICK, 1'b1, 24'hFFFFFF, 1'b0, '0},
      '{OP_EDGE, 1'b1, 24'd0, 1'b0, '0},
      '{OP_TICK, 1'b0, 24'd500, 1'b0, '0},
      '{OP_TICK, 1'b0, 24'h800000, 1'b0, '0},
      '{OP_TICK, 1'b0, 24'h555555, 1'b0, '0}
   };

   initial begin
      int phase, n, bias, pick;
      logic [23:0] el;
      req.valid = 1'b0;
      req.opcode = OP_EDGE;
      req.direction = 1'b0;
      req.elapsed_us = '0;
      cfg = '{target_rpm: 24'sd0, prop_gain: 16'd2560, integral_gain: 16'd26,
              counts_per_rev: 16'd1000, drive_limit: 15'd32767};
      count_now = '0;
      count_at_tick = '0;
      prev_raw = 0;
      filt_speed = 0;
      err_integral = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         send_beat(directed_rows[k].opcode, directed_rows[k].direction,
                   directed_rows[k].elapsed_us, directed_rows[k].typed,
                   directed_rows[k].known);
      req.valid <= 1'b0;

      for (phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_reg(CSR_TARGET, 24'h7FFFFF);
               write_reg(CSR_PROP, 24'hFFFF);
               write_reg(CSR_INTEG, 24'hFFFF);
               write_reg(CSR_CPR, 24'd1);
               write_reg(CSR_LIMIT, 24'h7FFF);
            end
            1: begin
               write_reg(CSR_TARGET, 24'h800000);
               write_reg(CSR_PROP, 24'd0);
               write_reg(CSR_INTEG, 24'd0);
               write_reg(CSR_CPR, 24'hFFFF);
               write_reg(CSR_LIMIT, 24'd0);
            end
            default: begin
               write_reg(CSR_TARGET, 24'($urandom));
               write_reg(CSR_PROP, 24'($urandom_range(0, 65535)));
               write_reg(CSR_INTEG, 24'($urandom_range(0, 65535)));
               write_reg(CSR_CPR, 24'($urandom_range(1, 65535)));
               write_reg(CSR_LIMIT, 24'($urandom_range(0, 32767)));
            end
         endcase
         csr_we <= 1'b0;
         bias = $urandom_range(0, 100);
         for (n = 0; n < 100; n++) begin
            if (phase == 4 && n >= 60) quiet = 1'b1;
            if ($urandom_range(0, 9) < 6) begin
               send_beat(OP_EDGE, $urandom_range(0, 99) < bias, 24'($urandom), 1'b0, '0);
            end else begin
               pick = $urandom_range(0, 19);
               if (pick == 0) el = 24'd0;
               else if (pick < 14) el = 24'($urandom_range(1, 2000));
               else el = 24'($urandom);
               send_beat(OP_TICK, 1'($urandom_range(0, 1)), el, 1'b0, '0);
            end
         end
         req.valid <= 1'b0;
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
